// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PRFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define PRFS_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

`endif

// ----- sv/prfs_pkg.sv -----
`timescale 1ns / 1ps

package prfs_pkg;

    // command codes
    localparam logic [1:0] CMD_WR_METRIC = 2'd0;
    localparam logic [1:0] CMD_RD_METRIC = 2'd1;
    localparam logic [1:0] CMD_WR_GROUP  = 2'd2;
    localparam logic [1:0] CMD_RD_GROUP  = 2'd3;

    // word layout
    localparam int unsigned FLAG_SHIFT = 28;
    localparam int unsigned LANES      = 16;
    localparam int unsigned MAX_LEN    = 8;

    // words_per_row register
    localparam int unsigned   WPR_W     = 3;
    localparam logic [WPR_W-1:0] WPR_RESET = 3'd1;

    // input beat
    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         doc_id;
        logic [1:0]         word_index;
        logic [3:0]         byte_start;
        logic [3:0]         byte_len;
        logic               is_flag;
        logic [1:0]         flag_bit;
        logic signed [63:0] bias;
        logic signed [63:0] value;
        logic               last_in_batch;
    } prfs_in_t;

    // result beat
    typedef struct packed {
        logic signed [63:0] read_value;
        logic               error;
        logic               last;
    } prfs_out_t;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic lookup;
        logic commit;
    } prfs_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } prfs_sts_t;

endpackage

// ----- sv/prfs_ram.sv -----
`timescale 1ns / 1ps

module prfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/prfs_ctrl.sv -----
`timescale 1ns / 1ps

module prfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prfs_pkg::prfs_sts_t sts,
    output prfs_pkg::prfs_ctl_t ctl
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOK   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // sequencing: clear sweep, then accept / read / modify-write
    always_comb begin
        state_next  = state_reg;
        ctl         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctl.clr_en = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctl.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                ctl.lookup = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/prfs_dp.sv -----
`timescale 1ns / 1ps

module prfs_dp #(
    parameter int ROWS       = 1024,
    parameter int MAX_WORDS  = 4,
    parameter int FLAG_BITS  = 4,
    parameter int GROUP_BITS = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  prfs_pkg::prfs_ctl_t         ctl,
    output prfs_pkg::prfs_sts_t         sts,
    input  prfs_pkg::prfs_in_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output prfs_pkg::prfs_out_t         m_item,
    input  logic                        cfg_valid,
    input  logic [prfs_pkg::WPR_W-1:0]  cfg_data
);

    localparam int DEPTH = ROWS * MAX_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW > 14) ? AW : 14;
    localparam logic [63:0] GMASK = (64'h1 << GROUP_BITS) - 64'h1;

    prfs_pkg::prfs_in_t              item_reg;
    logic [prfs_pkg::WPR_W-1:0]      wpr_reg;
    logic [AW-1:0]                   addr_reg;
    logic                            err_reg;
    logic [63:0]                     diff_reg;
    logic [AW-1:0]                   clr_addr_reg;
    prfs_pkg::prfs_out_t             out_reg;
    logic                            out_valid_reg;

    logic [CW-1:0]  addr_full;
    logic [AW-1:0]  addr_next;
    logic           err_next;
    logic           metric;
    logic           flag;
    logic           bad_cfg;
    logic           bad_doc;
    logic           bad_flag;
    logic           bad_metric;
    logic [4:0]     lane_end;

    logic [63:0]    rd_lo;
    logic [63:0]    rd_hi;
    logic [127:0]   word_old;
    logic [127:0]   word_new;
    logic [6:0]     sh_bits;
    logic [3:0]     drop;
    logic [63:0]    len_mask;
    logic [127:0]   wmask;
    logic [127:0]   wdata;
    logic [63:0]    extract;
    logic [5:0]     fpos;
    logic [63:0]    fmask;
    logic [63:0]    addend;
    logic [63:0]    sum;
    logic [63:0]    rv_next;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [127:0]   ram_wdata;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpr_reg <= prfs_pkg::WPR_RESET;
        end else if (cfg_valid) begin
            wpr_reg <= cfg_data;
        end
    end

    // range checks and row address for the captured item
    assign metric   = ~item_reg.cmd[1];
    assign flag     = metric & item_reg.is_flag;
    assign lane_end = {1'b0, item_reg.byte_start} + {1'b0, item_reg.byte_len};
    assign bad_cfg  = (wpr_reg == '0) || ({2'b0, wpr_reg} > 5'(MAX_WORDS));
    assign bad_doc  = {1'b0, 16'(item_reg.doc_id)} >= 17'(ROWS);
    assign bad_flag = flag && ({1'b0, item_reg.flag_bit} >= 3'(FLAG_BITS));
    assign bad_metric = metric && !item_reg.is_flag &&
                        (({1'b0, item_reg.word_index} >= wpr_reg) ||
                         (item_reg.byte_len == 4'd0) ||
                         (item_reg.byte_len > 4'(prfs_pkg::MAX_LEN)) ||
                         (lane_end > 5'(prfs_pkg::LANES)));
    assign err_next = bad_cfg | bad_doc | bad_flag | bad_metric;

    // group and flag commands live in word 0 of the row
    assign addr_full = CW'(item_reg.doc_id) * CW'(wpr_reg) +
                       ((metric && !item_reg.is_flag) ? CW'(item_reg.word_index) : '0);
    assign addr_next = addr_full[AW-1:0];

    // item capture and lookup stage
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            item_reg <= s_item;
        end
        if (ctl.lookup) begin
            addr_reg <= addr_next;
            err_reg  <= err_next;
            diff_reg <= item_reg.value - item_reg.bias;
        end
    end

    // clear sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (ctl.clr_en) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign sts.clear_done = (clr_addr_reg == AW'(DEPTH - 1));

    // store halves: lanes 0..7 and lanes 8..15 of each word
    assign ram_we    = ctl.clr_en | (ctl.commit & ~err_reg);
    assign ram_waddr = ctl.clr_en ? clr_addr_reg : addr_reg;
    assign ram_wdata = ctl.clr_en ? '0 : word_new;

    prfs_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_ram_lo (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata[63:0]),
        .re      (ctl.lookup),
        .rd_addr (addr_next),
        .rd_data (rd_lo)
    );

    prfs_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_ram_hi (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata[127:64]),
        .re      (ctl.lookup),
        .rd_addr (addr_next),
        .rd_data (rd_hi)
    );

    // lane masks and shifted write data
    assign word_old = {rd_hi, rd_lo};
    assign sh_bits  = {item_reg.byte_start, 3'b000};
    assign drop     = 4'(prfs_pkg::MAX_LEN) - item_reg.byte_len;
    assign len_mask = {64{1'b1}} >> {drop[2:0], 3'b000};
    assign wmask    = {64'h0, len_mask} << sh_bits;
    assign wdata    = {64'h0, diff_reg} << sh_bits;
    assign extract  = 64'(word_old >> sh_bits) & len_mask;
    assign fpos     = 6'(prfs_pkg::FLAG_SHIFT) + {4'b0, item_reg.flag_bit};
    assign fmask    = 64'h1 << fpos;

    // read result: zero-extended lanes or flag bit plus bias
    assign addend = flag ? {63'b0, |(rd_lo & fmask)} : extract;
    assign sum    = addend + item_reg.bias;

    // modify step
    always_comb begin
        word_new = word_old;
        rv_next  = '0;
        case (item_reg.cmd)
            prfs_pkg::CMD_WR_METRIC: begin
                if (item_reg.is_flag) begin
                    word_new[63:0] = (rd_lo & ~fmask) | (diff_reg[0] ? fmask : 64'h0);
                end else begin
                    word_new = (word_old & ~wmask) | (wdata & wmask);
                end
            end
            prfs_pkg::CMD_RD_METRIC: begin
                rv_next = sum;
            end
            prfs_pkg::CMD_WR_GROUP: begin
                word_new[63:0] = (rd_lo & ~GMASK) | (64'(item_reg.value) & GMASK);
            end
            default: begin
                rv_next = rd_lo & GMASK;
            end
        endcase
        if (err_reg) begin
            rv_next = '0;
        end
    end

    // result register
    assign sts.out_free = ~out_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            out_reg.read_value <= rv_next;
            out_reg.error      <= err_reg;
            out_reg.last       <= item_reg.last_in_batch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// ----- sv/packed_record_field_store.sv -----
// result beat: registered on commit, after the capture and lookup states; the commit
//   waits while the output register still holds a result that has not been taken
// one item at a time (capture, store read, modify-write) on the store's single RMW port pair
// a new item is taken while the previous result still waits in the output register
// reset: synchronous active-low; clears words_per_row to 1, then sweeps all ROWS*MAX_WORDS
//   store words (4096 by default) to zero with s_ready low
`timescale 1ns / 1ps

`include "assert_macros.svh"

module packed_record_field_store #(
    parameter int ROWS       = 1024,
    parameter int MAX_WORDS  = 4,
    parameter int FLAG_BITS  = 4,
    parameter int GROUP_BITS = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  prfs_pkg::prfs_in_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output prfs_pkg::prfs_out_t         m_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [prfs_pkg::WPR_W-1:0]  cfg_data
);

    prfs_pkg::prfs_ctl_t ctl;
    prfs_pkg::prfs_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    prfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    prfs_dp #(
        .ROWS       (ROWS),
        .MAX_WORDS  (MAX_WORDS),
        .FLAG_BITS  (FLAG_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

    // checks
    `PRFS_ASSERT(a_accept_then_lookup, aclk, aresetn, (s_valid && s_ready) |=> (ctl.lookup && !s_ready), "accepted beat not followed by store lookup")
    `PRFS_NEVER(a_clear_exclusive, aclk, aresetn, ctl.clr_en && (ctl.lookup || ctl.commit || s_ready), "clear sweep overlaps item work")
    `PRFS_ASSERT(a_commit_shows_result, aclk, aresetn, ctl.commit |=> m_valid, "commit did not present a result beat")
    `PRFS_ASSERT(a_lookup_then_commit_slot, aclk, aresetn, ctl.lookup |=> !ctl.lookup, "back-to-back lookups")

endmodule
